[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");

`else

`define ASSERT_AT(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[sv/ccp_pkg.sv]
// ----------------------------------------------------------------------------
// ccp_pkg
// shared types and constants of the coverage pileup unit
// ----------------------------------------------------------------------------
package ccp_pkg;

	localparam int REF_DEPTH_DEF         = 65536;
	localparam int COVERAGE_WIDTH_DEF    = 24;
	localparam int QUALITY_SUM_WIDTH_DEF = 40;

	localparam int POS_W    = 17;
	localparam int LEN_W    = 16;
	localparam int QSQ_W    = 16;
	localparam int OUT_COV_W = 24;
	localparam int OUT_QS_W  = 40;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam int S_TDATA_W  = 64;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 88;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_REF_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_CIGAR = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_MATCH  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	typedef struct packed {
		op_t              op;
		logic [15:0]      start_position;
		logic             is_mapped;
		logic [7:0]       map_quality;
		kind_t            cigar_kind;
		logic [LEN_W-1:0] cigar_length;
		logic [15:0]      read_index;
	} item_t;

	typedef struct packed {
		logic                 accepted;
		logic [OUT_COV_W-1:0] coverage_value;
		logic [OUT_QS_W-1:0]  quality_sum_value;
		logic [POS_W-1:0]     uncovered_total;
		logic                 out_of_range;
	} result_t;

	typedef struct packed {
		logic load_item;
		logic start;
		logic skip;
		logic mem_rd;
		logic base_skip;
		logic base_update;
		logic read_issue;
		logic clear_write;
		logic clear_done;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		op_t   op;
		kind_t kind;
		logic  active;
		logic  len_zero;
		logic  pos_in_range;
		logic  clr_last;
	} status_t;

endpackage

[sv/ccp_ctrl.sv]
// ----------------------------------------------------------------------------
// ccp_ctrl
// sequencer for request decode, base walk, store sweep and result handoff
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_ctrl
	import ccp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_BOOT_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MATCH,
		ST_MATCH_WR,
		ST_OP_CLEAR,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_BOOT_CLEAR: begin
				cmd.clear_write = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.op)
					OP_START: begin
						cmd.start = 1'b1;
						state_d   = ST_FINISH;
					end
					OP_CIGAR: begin
						if (sts.active && sts.kind == KIND_MATCH) begin
							state_d = ST_MATCH;
						end else begin
							cmd.skip = sts.active && sts.kind == KIND_DELETE;
							state_d  = ST_FINISH;
						end
					end
					OP_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = ST_FINISH;
					end
					OP_CLEAR: begin
						state_d = ST_OP_CLEAR;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_MATCH: begin
				if (sts.len_zero) begin
					state_d = ST_FINISH;
				end else if (sts.pos_in_range) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_MATCH_WR;
				end else begin
					cmd.base_skip = 1'b1;
				end
			end
			ST_MATCH_WR: begin
				cmd.base_update = 1'b1;
				state_d         = ST_MATCH;
			end
			ST_OP_CLEAR: begin
				cmd.clear_write = 1'b1;
				if (sts.clr_last) begin
					cmd.clear_done = 1'b1;
					state_d        = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_AT(a_one_request_at_a_time, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	`ASSERT_AT(a_write_follows_read, clk, arst_n, (state_q == ST_MATCH_WR) |-> $past(cmd.mem_rd))
	`ASSERT_NEVER(a_no_result_overwrite, clk, arst_n, cmd.load_result && out_valid_q && !m_tready)

endmodule

[sv/ccp_dp.sv]
// ----------------------------------------------------------------------------
// ccp_dp
// pileup datapath: position tracking, coverage and quality stores, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccp_dp
	import ccp_pkg::*;
#(
	parameter int REF_DEPTH         = REF_DEPTH_DEF,
	parameter int COVERAGE_WIDTH    = COVERAGE_WIDTH_DEF,
	parameter int QUALITY_SUM_WIDTH = QUALITY_SUM_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] ref_len,
	input  item_t            item,
	input  cmd_t             cmd,
	output status_t          sts,
	output result_t          result
);

	localparam int AW = $clog2(REF_DEPTH);
	localparam int CW = COVERAGE_WIDTH;
	localparam int QW = QUALITY_SUM_WIDTH;

	logic [CW-1:0] cov_mem [REF_DEPTH];
	logic [QW-1:0] qs_mem  [REF_DEPTH];

	item_t            item_q;
	logic [POS_W-1:0] pos_q;
	logic [QSQ_W-1:0] qsq_q;
	logic             active_q;
	logic [POS_W-1:0] unc_q;
	logic [LEN_W-1:0] rem_q;
	logic             oor_q;
	logic [AW-1:0]    clr_addr_q;
	logic [CW-1:0]    rd_cov_q;
	logic [QW-1:0]    rd_qs_q;
	result_t          result_q;

	logic [POS_W-1:0] eff_len;
	logic             pos_in_range;
	logic             idx_in_range;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W:0]   del_sum;
	logic [POS_W-1:0] pos_del;
	logic [CW-1:0]    cov_new;
	logic [QW:0]      qs_sum;
	logic [QW-1:0]    qs_new;
	logic [QSQ_W-1:0] mq_sq;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [CW-1:0]    wr_cov;
	logic [QW-1:0]    wr_qs;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [LEN_W-1:0] rem_dec;
	logic             base_step;

	assign eff_len = (32'(ref_len) < 32'(REF_DEPTH)) ? ref_len : POS_W'(REF_DEPTH);
	assign pos_in_range = pos_q < eff_len;
	assign idx_in_range = {1'b0, item_q.read_index} < eff_len;

	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign del_sum = {1'b0, pos_q} + {2'b00, item_q.cigar_length};
	assign pos_del = (del_sum > {1'b0, POS_MAX}) ? POS_MAX : del_sum[POS_W-1:0];

	assign cov_new = (&rd_cov_q) ? rd_cov_q : rd_cov_q + 1'b1;
	assign qs_sum  = {1'b0, rd_qs_q} + {{(QW + 1 - QSQ_W){1'b0}}, qsq_q};
	assign qs_new  = qs_sum[QW] ? '1 : qs_sum[QW-1:0];

	assign mq_sq = {8'b0, item_q.map_quality} * {8'b0, item_q.map_quality};

	assign rem_dec   = rem_q - 1'b1;
	assign base_step = cmd.base_update || cmd.base_skip;

	assign wr_en   = cmd.clear_write || cmd.base_update;
	assign wr_addr = cmd.clear_write ? clr_addr_q : AW'(pos_q);
	assign wr_cov  = cmd.clear_write ? '0 : cov_new;
	assign wr_qs   = cmd.clear_write ? '0 : qs_new;
	assign rd_en   = cmd.mem_rd || cmd.read_issue;
	assign rd_addr = cmd.read_issue ? AW'(item_q.read_index) : AW'(pos_q);

	assign sts.op           = item_q.op;
	assign sts.kind         = item_q.cigar_kind;
	assign sts.active       = active_q;
	assign sts.len_zero     = (rem_q == '0);
	assign sts.pos_in_range = pos_in_range;
	assign sts.clr_last     = (clr_addr_q == AW'(REF_DEPTH - 1));

	assign result = result_q;

	// store ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cov_mem[wr_addr] <= wr_cov;
			qs_mem[wr_addr]  <= wr_qs;
		end
		if (rd_en) begin
			rd_cov_q <= cov_mem[rd_addr];
			rd_qs_q  <= qs_mem[rd_addr];
		end
	end

	// request latch and result
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.load_result) begin
			result_q.accepted          <= (item_q.op == OP_START) ? item_q.is_mapped : 1'b1;
			result_q.coverage_value    <= (item_q.op == OP_READ && idx_in_range) ?
				OUT_COV_W'(rd_cov_q) : '0;
			result_q.quality_sum_value <= (item_q.op == OP_READ && idx_in_range) ?
				OUT_QS_W'(rd_qs_q) : '0;
			result_q.uncovered_total   <= unc_q;
			result_q.out_of_range      <= (item_q.op == OP_READ) ? !idx_in_range :
				(item_q.op == OP_CIGAR) ? oor_q : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			qsq_q      <= '0;
			active_q   <= 1'b0;
			unc_q      <= '0;
			rem_q      <= '0;
			oor_q      <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.load_item) begin
				rem_q <= item.cigar_length;
				oor_q <= 1'b0;
			end
			if (cmd.start) begin
				active_q <= item_q.is_mapped;
				if (item_q.is_mapped) begin
					pos_q <= {1'b0, item_q.start_position};
					qsq_q <= mq_sq;
				end
			end
			if (cmd.skip) begin
				pos_q <= pos_del;
			end
			if (cmd.base_skip) begin
				oor_q <= 1'b1;
				pos_q <= pos_inc;
				rem_q <= rem_dec;
			end
			if (cmd.base_update) begin
				if (rd_cov_q == '0 && unc_q != '0) begin
					unc_q <= unc_q - 1'b1;
				end
				pos_q <= pos_inc;
				rem_q <= rem_dec;
			end
			if (cmd.clear_write) begin
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + 1'b1;
			end
			if (cmd.clear_done) begin
				unc_q    <= eff_len;
				active_q <= 1'b0;
			end
		end
	end

	`ASSERT_AT(a_update_in_range, clk, arst_n, cmd.base_update |-> pos_in_range)
	`ASSERT_AT(a_base_counts_down, clk, arst_n, base_step |=> (rem_q == $past(rem_dec)))
	`ASSERT_NEVER(a_sweep_vs_update, clk, arst_n, cmd.clear_write && (cmd.base_update || rd_en))

endmodule

[sv/cigar_coverage_pileup_unit.sv]
// ----------------------------------------------------------------------------
// cigar_coverage_pileup_unit
// per-base read coverage and squared-quality pileup over one reference
// ----------------------------------------------------------------------------
// requests enter on the s_ stream (op in s_tuser), one result per request
// leaves on the m_ stream. the user writes reference_length over the apb
// port only while the unit is idle; the unit itself does not enforce this.
// start, insertion, deletion, other ops and reads pass from decode straight
// to the result. a match run does a read-modify-write of the coverage and
// quality stores for each base inside the reference and steps over each
// base beyond it. a clear sweeps all REF_DEPTH store entries, one store
// entry per cycle. one request is worked on at a time; the next is taken
// the cycle after the result is loaded into the output register, even if
// the receiver has not taken it. after reset the stores are swept to zero
// over all REF_DEPTH entries, during which s_tready stays low; apb writes
// are taken throughout. when the receiver stalls the result holds and the
// unit finishes the next request up to its result, then waits.
// ----------------------------------------------------------------------------
module cigar_coverage_pileup_unit
	import ccp_pkg::*;
#(
	parameter int REF_DEPTH         = REF_DEPTH_DEF,
	parameter int COVERAGE_WIDTH    = COVERAGE_WIDTH_DEF,
	parameter int QUALITY_SUM_WIDTH = QUALITY_SUM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// start_position[15:0], is_mapped[16], map_quality[24:17], cigar_kind[26:25],
	// cigar_length[42:27], read_index[58:43], zero[63:59]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// accepted[0], coverage_value[24:1], quality_sum_value[64:25],
	// uncovered_total[81:65], out_of_range[82], zero[87:83]
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [POS_W-1:0] ref_len_q;
	item_t            item;
	cmd_t             cmd;
	status_t          sts;
	result_t          result;

	// register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_REF_LENGTH) ? APB_DATA_W'(ref_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_REF_LENGTH) begin
			ref_len_q <= pwdata[POS_W-1:0];
		end
	end

	// request unpacking
	assign item.op             = op_t'(s_tuser[1:0]);
	assign item.start_position = s_tdata[15:0];
	assign item.is_mapped      = s_tdata[16];
	assign item.map_quality    = s_tdata[24:17];
	assign item.cigar_kind     = kind_t'(s_tdata[26:25]);
	assign item.cigar_length   = s_tdata[42:27];
	assign item.read_index     = s_tdata[58:43];

	assign m_tdata = {5'b0, result.out_of_range, result.uncovered_total,
		result.quality_sum_value, result.coverage_value, result.accepted};

	ccp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccp_dp #(
		.REF_DEPTH         (REF_DEPTH),
		.COVERAGE_WIDTH    (COVERAGE_WIDTH),
		.QUALITY_SUM_WIDTH (QUALITY_SUM_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ref_len (ref_len_q),
		.item    (item),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

[tb/cigar_coverage_pileup_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_coverage_pileup_unit_checker
// watches the request, result and apb channels of the pileup unit, keeps its
// own coverage and quality-sum stores, predicts one result per request and
// compares every result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module cigar_coverage_pileup_unit_checker
	import ccp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic [S_TUSER_W-1:0]  s_tuser,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int DEPTH = REF_DEPTH_DEF;
	localparam logic [COVERAGE_WIDTH_DEF-1:0]    COV_SAT  = '1;
	localparam logic [QUALITY_SUM_WIDTH_DEF-1:0] QSUM_SAT = '1;
	localparam logic [APB_ADDR_W-1:0] REF_LENGTH_ADDR = APB_ADDR_W'(4 * REG_REF_LENGTH);

	logic [COVERAGE_WIDTH_DEF-1:0]    cov_mem  [DEPTH];
	logic [QUALITY_SUM_WIDTH_DEF-1:0] qsum_mem [DEPTH];
	logic [POS_W-1:0] walk_pos;
	logic [QSQ_W-1:0] qual_sq;
	logic             walk_open;
	logic [POS_W-1:0] uncovered;
	logic [POS_W-1:0] ref_len;
	result_t          pileup_results [$];

	function automatic int eff_len();
		return (ref_len > DEPTH) ? DEPTH : int'(ref_len);
	endfunction

	function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] p, int n);
		int s;
		s = int'(p) + n;
		return (s > int'(POS_MAX)) ? POS_MAX : s[POS_W-1:0];
	endfunction

	function automatic void clear_store();
		foreach (cov_mem[i]) begin
			cov_mem[i]  = '0;
			qsum_mem[i] = '0;
		end
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, seen);
		end
	endtask

	function automatic result_t pileup_step(item_t it);
		result_t r;
		int lim;
		int p;
		int i;
		r = '0;
		r.accepted = 1'b1;
		lim = eff_len();
		case (it.op)
			OP_START: begin
				if (it.is_mapped) begin
					walk_pos  = POS_W'(it.start_position);
					qual_sq   = it.map_quality * it.map_quality;
					walk_open = 1'b1;
				end else begin
					walk_open  = 1'b0;
					r.accepted = 1'b0;
				end
			end
			OP_CIGAR: begin
				if (walk_open && it.cigar_kind == KIND_MATCH) begin
					for (i = 0; i < int'(it.cigar_length); i++) begin
						p = int'(walk_pos);
						if (p < lim) begin
							if (cov_mem[p] == '0 && uncovered != '0)
								uncovered--;
							if (cov_mem[p] != COV_SAT)
								cov_mem[p]++;
							if (qsum_mem[p] > QSUM_SAT - qual_sq)
								qsum_mem[p] = QSUM_SAT;
							else
								qsum_mem[p] = qsum_mem[p] + qual_sq;
						end else begin
							r.out_of_range = 1'b1;
						end
						walk_pos = step_pos(walk_pos, 1);
					end
				end else if (walk_open && it.cigar_kind == KIND_DELETE) begin
					walk_pos = step_pos(walk_pos, int'(it.cigar_length));
				end
			end
			OP_READ: begin
				if (int'(it.read_index) < lim) begin
					r.coverage_value    = OUT_COV_W'(cov_mem[it.read_index]);
					r.quality_sum_value = OUT_QS_W'(qsum_mem[it.read_index]);
				end else begin
					r.out_of_range = 1'b1;
				end
			end
			OP_CLEAR: begin
				clear_store();
				uncovered = POS_W'(lim);
				walk_open = 1'b0;
			end
		endcase
		r.uncovered_total = uncovered;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   req;
		result_t want;
		result_t seen;
		if (!arst_n) begin
			clear_store();
			walk_pos    = '0;
			qual_sq     = '0;
			walk_open   = 1'b0;
			uncovered   = '0;
			ref_len     = '0;
			mismatches  = 0;
			outstanding = 0;
			pileup_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				seen.accepted          = m_tdata[0];
				seen.coverage_value    = m_tdata[24:1];
				seen.quality_sum_value = m_tdata[64:25];
				seen.uncovered_total   = m_tdata[81:65];
				seen.out_of_range      = m_tdata[82];
				if (pileup_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request outstanding: %0h", m_tdata);
				end else begin
					want = pileup_results.pop_front();
					check_field("accepted", want.accepted, seen.accepted);
					check_field("coverage_value", want.coverage_value,
						seen.coverage_value);
					check_field("quality_sum_value", want.quality_sum_value,
						seen.quality_sum_value);
					check_field("uncovered_total", want.uncovered_total,
						seen.uncovered_total);
					check_field("out_of_range", want.out_of_range, seen.out_of_range);
				end
			end
			if (s_tvalid && s_tready) begin
				req.op             = op_t'(s_tuser);
				req.start_position = s_tdata[15:0];
				req.is_mapped      = s_tdata[16];
				req.map_quality    = s_tdata[24:17];
				req.cigar_kind     = kind_t'(s_tdata[26:25]);
				req.cigar_length   = s_tdata[42:27];
				req.read_index     = s_tdata[58:43];
				pileup_results.push_back(pileup_step(req));
			end
			if (psel && penable && pready && paddr == REF_LENGTH_ADDR) begin
				if (pwrite)
					ref_len = pwdata[POS_W-1:0];
				else
					check_field("prdata", {{(64-POS_W){1'b0}}, ref_len}, prdata);
			end
			outstanding = pileup_results.size();
		end
	end

endmodule

[tb/cigar_coverage_pileup_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_coverage_pileup_unit_tb
// request stimulus and verdict for the coverage pileup unit: a directed pass
// over the corner cases, then phases of random alignments and noise under
// several reference lengths, with random stalls on both streams
// ----------------------------------------------------------------------------
module cigar_coverage_pileup_unit_tb;
	import ccp_pkg::*;

	localparam int QUIET_LIMIT = 600000;
	localparam logic [APB_ADDR_W-1:0] REF_LENGTH_ADDR = APB_ADDR_W'(4 * REG_REF_LENGTH);

	logic                  clk;
	logic                  arst_n;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int          fail_count;
	int          open_results;
	bit          idle_on = 1'b1;
	int          cur_len = 0;
	int          items_sent = 0;
	logic [15:0] last_start = '0;

	cigar_coverage_pileup_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cigar_coverage_pileup_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.m_tdata     (m_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.mismatches  (fail_count),
		.outstanding (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= !idle_on || ($urandom_range(99) >= 6);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("cigar_coverage_pileup_unit verification failed");
		$finish;
	end

	function automatic item_t noise_req();
		item_t it;
		it.op             = op_t'($urandom_range(3));
		it.start_position = 16'($urandom);
		it.is_mapped      = 1'($urandom_range(1));
		it.map_quality    = 8'($urandom);
		it.cigar_kind     = kind_t'($urandom_range(3));
		it.cigar_length   = 16'($urandom);
		it.read_index     = 16'($urandom);
		return it;
	endfunction

	function automatic int match_len();
		return ($urandom_range(99) < 2) ? $urandom_range(3000, 600) : $urandom_range(100);
	endfunction

	function automatic logic [15:0] pick_pos();
		int p;
		case ($urandom_range(9))
			0:       p = $urandom_range(65535);
			1:       p = cur_len - 10 + $urandom_range(20);
			default: p = (cur_len == 0) ? $urandom_range(30) : $urandom_range(cur_len - 1);
		endcase
		if (p < 0)
			p = 0;
		if (p > 65535)
			p = 65535;
		return p[15:0];
	endfunction

	task automatic send_req(input item_t it);
		while (idle_on && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {5'b0, it.read_index, it.cigar_length, it.cigar_kind, it.map_quality,
			it.is_mapped, it.start_position};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_start(input logic [15:0] pos, input logic mapped,
			input logic [7:0] mq);
		item_t it;
		it = noise_req();
		it.op             = OP_START;
		it.start_position = pos;
		it.is_mapped      = mapped;
		it.map_quality    = mq;
		send_req(it);
	endtask

	task automatic send_cigar(input kind_t kind, input int len);
		item_t it;
		it = noise_req();
		it.op           = OP_CIGAR;
		it.cigar_kind   = kind;
		it.cigar_length = 16'(len);
		send_req(it);
	endtask

	task automatic send_read(input logic [15:0] idx);
		item_t it;
		it = noise_req();
		it.op         = OP_READ;
		it.read_index = idx;
		send_req(it);
	endtask

	task automatic send_clear();
		item_t it;
		it = noise_req();
		it.op = OP_CLEAR;
		send_req(it);
	endtask

	task automatic send_noise();
		item_t it;
		it = noise_req();
		if (it.op == OP_CLEAR)
			it.op = OP_READ;
		if (it.op == OP_CIGAR && it.cigar_kind == KIND_MATCH)
			it.cigar_length = 16'(match_len());
		send_req(it);
	endtask

	// hold off requests until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (open_results == 0);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REF_LENGTH_ADDR;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_ref_length(input int len);
		drain();
		apb_access(1'b1, APB_DATA_W'(len));
		apb_access(1'b0, '0);
		cur_len = len;
	endtask

	task automatic run_alignment();
		int k;
		int idx;
		last_start = pick_pos();
		send_start(last_start, $urandom_range(99) < 85, 8'($urandom));
		repeat ($urandom_range(6, 1)) begin
			k = $urandom_range(99);
			if (k < 50)
				send_cigar(KIND_MATCH, match_len());
			else if (k < 75)
				send_cigar(KIND_DELETE,
					($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40));
			else if (k < 90)
				send_cigar(KIND_INSERT, $urandom_range(65535));
			else
				send_cigar(KIND_OTHER, $urandom_range(65535));
		end
		repeat ($urandom_range(3)) begin
			idx = int'(last_start) + $urandom_range(80);
			if ($urandom_range(1) == 0)
				send_read(pick_pos());
			else
				send_read((idx > 65535) ? 16'hFFFF : idx[15:0]);
		end
	endtask

	initial begin
		int ref_lengths [7];
		int phase_end;
		ref_lengths = '{65536, 1000, 0, 300, 65535, 40, 65536};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b1;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corner cases
		set_ref_length(65536);
		send_read(16'd0);
		send_clear();
		send_cigar(KIND_MATCH, 5);
		send_start(16'd100, 1'b0, 8'd200);
		send_cigar(KIND_MATCH, 5);
		send_start(16'd65530, 1'b1, 8'd255);
		send_cigar(KIND_MATCH, 10);
		send_read(16'd65535);
		send_start(16'd0, 1'b1, 8'd0);
		send_cigar(KIND_MATCH, 0);
		send_cigar(KIND_INSERT, 65535);
		send_cigar(KIND_OTHER, 65535);
		send_cigar(KIND_DELETE, 3);
		send_cigar(KIND_MATCH, 2);
		send_read(16'd3);
		send_start(16'd65535, 1'b1, 8'd1);
		send_cigar(KIND_DELETE, 65535);
		send_cigar(KIND_DELETE, 65535);
		send_cigar(KIND_MATCH, 3);
		set_ref_length(300);
		send_read(16'd299);
		send_read(16'd300);
		send_start(16'd290, 1'b1, 8'd77);
		send_cigar(KIND_MATCH, 65535);
		send_clear();

		// random phases
		foreach (ref_lengths[ph]) begin
			set_ref_length(ref_lengths[ph]);
			idle_on = (ph != 4);
			if (ph == 0 || ph == 3 || ph == 5)
				send_clear();
			phase_end = items_sent + 155;
			while (items_sent < phase_end) begin
				if ($urandom_range(49) == 0)
					drain();
				if ($urandom_range(9) < 8)
					run_alignment();
				else
					repeat ($urandom_range(3, 1)) send_noise();
			end
		end
		idle_on = 1'b1;

		s_tvalid <= 1'b0;
		wait (open_results == 0);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("cigar_coverage_pileup_unit verification clean");
		else
			$display("cigar_coverage_pileup_unit verification failed");
		$finish;
	end

endmodule

[cigar_coverage_pileup_unit.f]
+incdir+sv
sv/ccp_pkg.sv
sv/ccp_ctrl.sv
sv/ccp_dp.sv
sv/cigar_coverage_pileup_unit.sv
tb/cigar_coverage_pileup_unit_checker.sv
tb/cigar_coverage_pileup_unit_tb.sv
